>>> sv/bnc_pkg.sv
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types, constants and the symbol decoder for the bracket nesting
// checker.
// ----------------------------------------------------------------------------
package bnc_pkg;

   // Bracket kinds as held on the stack.
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ROUND  = 2'd0;
   localparam kind_type KIND_SQUARE = 2'd1;
   localparam kind_type KIND_CURLY  = 2'd2;
   localparam kind_type KIND_ANGLE  = 2'd3;

   // ASCII codes of the brackets.
   localparam logic [7:0] ASCII_OPEN_ROUND   = 8'h28; // (
   localparam logic [7:0] ASCII_OPEN_SQUARE  = 8'h5B; // [
   localparam logic [7:0] ASCII_OPEN_CURLY   = 8'h7B; // {
   localparam logic [7:0] ASCII_OPEN_ANGLE   = 8'h3C; // <
   localparam logic [7:0] ASCII_CLOSE_ROUND  = 8'h29; // )
   localparam logic [7:0] ASCII_CLOSE_SQUARE = 8'h5D; // ]
   localparam logic [7:0] ASCII_CLOSE_CURLY  = 8'h7D; // }
   localparam logic [7:0] ASCII_CLOSE_ANGLE  = 8'h3E; // >

   // Line status codes.
   typedef logic [1:0] status_type;
   localparam status_type STATUS_GOOD       = 2'd0;
   localparam status_type STATUS_CORRUPTED  = 2'd1;
   localparam status_type STATUS_INCOMPLETE = 2'd2;
   localparam status_type STATUS_OVERFLOW   = 2'd3;

   // Register indexes of the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_COST_ROUND    = 3'd0;
   localparam csr_index_type CSR_COST_SQUARE   = 3'd1;
   localparam csr_index_type CSR_COST_CURLY    = 3'd2;
   localparam csr_index_type CSR_COST_ANGLE    = 3'd3;
   localparam csr_index_type CSR_REPAIR_ROUND  = 3'd4;
   localparam csr_index_type CSR_REPAIR_SQUARE = 3'd5;
   localparam csr_index_type CSR_REPAIR_CURLY  = 3'd6;
   localparam csr_index_type CSR_REPAIR_ANGLE  = 3'd7;

   // Field widths.
   localparam int unsigned COST_W   = 16;
   localparam int unsigned REPAIR_W = 4;
   localparam int unsigned SCORE_W  = 63;
   localparam int unsigned TOTAL_W  = 32;

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // Reset values of the registers.
   localparam logic [COST_W-1:0]   COST_ROUND_RST    = 16'd3;
   localparam logic [COST_W-1:0]   COST_SQUARE_RST   = 16'd57;
   localparam logic [COST_W-1:0]   COST_CURLY_RST    = 16'd1197;
   localparam logic [COST_W-1:0]   COST_ANGLE_RST    = 16'd25137;
   localparam logic [REPAIR_W-1:0] REPAIR_ROUND_RST  = 4'd1;
   localparam logic [REPAIR_W-1:0] REPAIR_SQUARE_RST = 4'd2;
   localparam logic [REPAIR_W-1:0] REPAIR_CURLY_RST  = 4'd3;
   localparam logic [REPAIR_W-1:0] REPAIR_ANGLE_RST  = 4'd4;

   // Configuration as seen by the datapath, indexed by bracket kind.
   typedef struct packed {
      logic [3:0][COST_W-1:0]   cost;
      logic [3:0][REPAIR_W-1:0] repair;
   } cfg_type;

   // Decoded symbol.
   typedef struct packed {
      logic     is_open;
      logic     is_close;
      kind_type kind;
   } sym_type;

   function automatic sym_type decode_symbol(input logic [7:0] symbol);
      sym_type d;
      d = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
      unique case (symbol)
         ASCII_OPEN_ROUND:   d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
         ASCII_OPEN_SQUARE:  d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
         ASCII_OPEN_CURLY:   d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
         ASCII_OPEN_ANGLE:   d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
         ASCII_CLOSE_ROUND:  d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
         ASCII_CLOSE_SQUARE: d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
         ASCII_CLOSE_CURLY:  d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
         ASCII_CLOSE_ANGLE:  d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
         default:            d = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
      endcase
      return d;
   endfunction

endpackage

>>> sv/bnc_ram.sv
// ----------------------------------------------------------------------------
// bnc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bnc_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bnc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bnc_cfg_regs
// Configuration registers: closer costs and repair values per bracket kind.
// ----------------------------------------------------------------------------
module bnc_cfg_regs (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  bnc_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata,
   output bnc_pkg::cfg_type       cfg
);

   bnc_pkg::cfg_type cfg_ff;
   bnc_pkg::cfg_type cfg_in;

   // Decode the register index; repair registers keep the low bits only.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bnc_pkg::CSR_COST_ROUND:    cfg_in.cost[bnc_pkg::KIND_ROUND]  = csr_wdata;
            bnc_pkg::CSR_COST_SQUARE:   cfg_in.cost[bnc_pkg::KIND_SQUARE] = csr_wdata;
            bnc_pkg::CSR_COST_CURLY:    cfg_in.cost[bnc_pkg::KIND_CURLY]  = csr_wdata;
            bnc_pkg::CSR_COST_ANGLE:    cfg_in.cost[bnc_pkg::KIND_ANGLE]  = csr_wdata;
            bnc_pkg::CSR_REPAIR_ROUND:
               cfg_in.repair[bnc_pkg::KIND_ROUND]  = csr_wdata[bnc_pkg::REPAIR_W-1:0];
            bnc_pkg::CSR_REPAIR_SQUARE:
               cfg_in.repair[bnc_pkg::KIND_SQUARE] = csr_wdata[bnc_pkg::REPAIR_W-1:0];
            bnc_pkg::CSR_REPAIR_CURLY:
               cfg_in.repair[bnc_pkg::KIND_CURLY]  = csr_wdata[bnc_pkg::REPAIR_W-1:0];
            bnc_pkg::CSR_REPAIR_ANGLE:
               cfg_in.repair[bnc_pkg::KIND_ANGLE]  = csr_wdata[bnc_pkg::REPAIR_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cost[bnc_pkg::KIND_ROUND]    <= bnc_pkg::COST_ROUND_RST;
         cfg_ff.cost[bnc_pkg::KIND_SQUARE]   <= bnc_pkg::COST_SQUARE_RST;
         cfg_ff.cost[bnc_pkg::KIND_CURLY]    <= bnc_pkg::COST_CURLY_RST;
         cfg_ff.cost[bnc_pkg::KIND_ANGLE]    <= bnc_pkg::COST_ANGLE_RST;
         cfg_ff.repair[bnc_pkg::KIND_ROUND]  <= bnc_pkg::REPAIR_ROUND_RST;
         cfg_ff.repair[bnc_pkg::KIND_SQUARE] <= bnc_pkg::REPAIR_SQUARE_RST;
         cfg_ff.repair[bnc_pkg::KIND_CURLY]  <= bnc_pkg::REPAIR_CURLY_RST;
         cfg_ff.repair[bnc_pkg::KIND_ANGLE]  <= bnc_pkg::REPAIR_ANGLE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/bnc_score_step.sv
// ----------------------------------------------------------------------------
// bnc_score_step
// One step of the completion score: score * 5 + repair, saturating at the
// largest 63-bit value.
// ----------------------------------------------------------------------------
module bnc_score_step (
   input  logic [bnc_pkg::SCORE_W-1:0]  score,
   input  logic [bnc_pkg::REPAIR_W-1:0] repair,
   output logic [bnc_pkg::SCORE_W-1:0]  next_score
);

   localparam int unsigned SUM_W = bnc_pkg::SCORE_W + 3;

   logic [SUM_W-1:0] sum;

   // Times five is a shift by two plus the value itself; the sum is exact in
   // three extra bits, so any of them set means the result saturates.
   always_comb begin
      sum = {1'b0, score, 2'b00}
          + {3'b000, score}
          + {{(SUM_W - bnc_pkg::REPAIR_W){1'b0}}, repair};
      if (sum[SUM_W-1:bnc_pkg::SCORE_W] != 3'b000) begin
         next_score = bnc_pkg::SCORE_MAX;
      end else begin
         next_score = sum[bnc_pkg::SCORE_W-1:0];
      end
   end

endmodule

>>> sv/bracket_nesting_checker.sv
// ----------------------------------------------------------------------------
// bracket_nesting_checker
// Checks bracket nesting over lines of ASCII characters and scores them.
// ----------------------------------------------------------------------------
// Usage: each req_ item carries one character (req_symbol, valid when
// req_symbol_present is high) and req_line_end marks the last item of a line.
// Only the item with req_line_end produces an rsp_ item: the line status, the
// cost of the first illegal closer, the completion score and the running
// error total. The csr_ port writes costs and repair values; write it only
// while the block is idle.
// Timing: req_ready is high only in the idle state. A pop that leaves the
// stack non-empty passes through the refill state, where the new top of
// stack is read back from the stack RAM. A line end passes through the
// finish state for evaluation; an incomplete line with D open entries then
// unwinds all D entries from the stack RAM, one entry per cycle through the
// shared score unit. The result then sits in the output registers until
// rsp_ready takes it, and no new item is accepted meanwhile.
// Reset: the stack, line flags and running total clear at once and the
// registers return to their default costs; there is no clearing pass.
// ----------------------------------------------------------------------------
module bracket_nesting_checker #(
   parameter int unsigned STACK_DEPTH = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_symbol,
   input  logic                   req_symbol_present,
   input  logic                   req_line_end,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_line_status,
   output logic [15:0]            rsp_error_cost,
   output logic [62:0]            rsp_completion_score,
   output logic [31:0]            rsp_total_error_cost,
   // Configuration port
   input  logic                   csr_wr_en,
   input  bnc_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
   localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REFILL,
      ST_FINISH,
      ST_UNWIND,
      ST_OUT
   } state_type;

   state_type                          state_ff, state_in;
   logic [DW-1:0]                      depth_ff, depth_in;
   logic                               corrupted_ff, corrupted_in;
   logic                               overflowed_ff, overflowed_in;
   logic [bnc_pkg::COST_W-1:0]         first_cost_ff, first_cost_in;
   logic [bnc_pkg::TOTAL_W-1:0]        total_ff, total_in;
   bnc_pkg::kind_type                  top_ff, top_in;
   logic                               end_ff, end_in;
   logic [DW-1:0]                      ptr_ff, ptr_in;
   logic                               pend_ff, pend_in;
   bnc_pkg::status_type                status_ff, status_in;
   logic [bnc_pkg::COST_W-1:0]         cost_ff, cost_in;
   logic [bnc_pkg::SCORE_W-1:0]        score_ff, score_in;

   bnc_pkg::cfg_type                   cfg;
   bnc_pkg::sym_type                   sym;
   logic                               active;
   logic [DW-1:0]                      depth_m2;
   logic [DW-1:0]                      ptr_m1;
   logic [bnc_pkg::TOTAL_W:0]          total_sum;
   logic [bnc_pkg::SCORE_W-1:0]        step_score;
   logic [bnc_pkg::REPAIR_W-1:0]       step_repair;

   logic                               ram_wr_en;
   logic [AW-1:0]                      ram_wr_addr;
   bnc_pkg::kind_type                  ram_wr_data;
   logic [AW-1:0]                      ram_rd_addr;
   bnc_pkg::kind_type                  ram_rd_data;

   bnc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bnc_ram #(
      .WIDTH ($bits(bnc_pkg::kind_type)),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared score unit, fed by the entry read back from the stack.
   assign step_repair = cfg.repair[ram_rd_data];

   bnc_score_step u_score (
      .score      (score_ff),
      .repair     (step_repair),
      .next_score (step_score)
   );

   assign sym       = bnc_pkg::decode_symbol(req_symbol);
   assign active    = req_symbol_present && !corrupted_ff && !overflowed_ff;
   assign depth_m2  = depth_ff - DW'(2);
   assign ptr_m1    = ptr_ff - DW'(1);
   assign total_sum = {1'b0, total_ff} + {{(bnc_pkg::TOTAL_W - bnc_pkg::COST_W + 1){1'b0}},
                                          first_cost_ff};

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // Sequencer: character handling, line evaluation and stack unwind.
   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      corrupted_in  = corrupted_ff;
      overflowed_in = overflowed_ff;
      first_cost_in = first_cost_ff;
      total_in      = total_ff;
      top_in        = top_ff;
      end_in        = end_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      status_in     = status_ff;
      cost_in       = cost_ff;
      score_in      = score_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = depth_ff[AW-1:0];
      ram_wr_data   = sym.kind;
      ram_rd_addr   = depth_m2[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               end_in   = req_line_end;
               state_in = req_line_end ? ST_FINISH : ST_IDLE;
               if (active && sym.is_open) begin
                  // Push, or mark the line overflowed when the stack is full.
                  if (depth_ff == DEPTH_FULL) begin
                     overflowed_in = 1'b1;
                  end else begin
                     ram_wr_en = 1'b1;
                     depth_in  = depth_ff + DW'(1);
                     top_in    = sym.kind;
                  end
               end else if (active && sym.is_close) begin
                  // Pop on a match; a new top is read back when one remains.
                  if (depth_ff != '0 && top_ff == sym.kind) begin
                     depth_in = depth_ff - DW'(1);
                     if (depth_ff > DW'(1)) begin
                        state_in = ST_REFILL;
                     end
                  end else begin
                     corrupted_in  = 1'b1;
                     first_cost_in = cfg.cost[sym.kind];
                  end
               end
            end
         end

         ST_REFILL: begin
            top_in   = ram_rd_data;
            state_in = end_ff ? ST_FINISH : ST_IDLE;
         end

         ST_FINISH: begin
            cost_in  = '0;
            score_in = '0;
            ptr_in   = depth_ff;
            pend_in  = 1'b0;
            state_in = ST_OUT;
            priority if (corrupted_ff) begin
               status_in = bnc_pkg::STATUS_CORRUPTED;
               cost_in   = first_cost_ff;
               total_in  = total_sum[bnc_pkg::TOTAL_W] ? bnc_pkg::TOTAL_MAX
                                                       : total_sum[bnc_pkg::TOTAL_W-1:0];
            end else if (overflowed_ff) begin
               status_in = bnc_pkg::STATUS_OVERFLOW;
            end else if (depth_ff != '0) begin
               status_in = bnc_pkg::STATUS_INCOMPLETE;
               state_in  = ST_UNWIND;
            end else begin
               status_in = bnc_pkg::STATUS_GOOD;
            end
         end

         ST_UNWIND: begin
            // Issue reads from the top down and fold each entry in the cycle after its read.
            ram_rd_addr = ptr_m1[AW-1:0];
            if (ptr_ff != '0) begin
               ptr_in  = ptr_m1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_OUT;
            end
            if (pend_ff) begin
               score_in = step_score;
            end
         end

         ST_OUT: begin
            if (rsp_ready) begin
               depth_in      = '0;
               corrupted_in  = 1'b0;
               overflowed_in = 1'b0;
               first_cost_in = '0;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         depth_ff      <= '0;
         corrupted_ff  <= 1'b0;
         overflowed_ff <= 1'b0;
         first_cost_ff <= '0;
         total_ff      <= '0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         corrupted_ff  <= corrupted_in;
         overflowed_ff <= overflowed_in;
         first_cost_ff <= first_cost_in;
         total_ff      <= total_in;
         pend_ff       <= pend_in;
      end
      top_ff    <= top_in;
      end_ff    <= end_in;
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      cost_ff   <= cost_in;
      score_ff  <= score_in;
   end

   assign rsp_line_status      = status_ff;
   assign rsp_error_cost       = cost_ff;
   assign rsp_completion_score = score_ff;
   assign rsp_total_error_cost = total_ff;

endmodule

>>> verif/line_result_checker.sv
// ----------------------------------------------------------------------------
// line_result_checker
// Watches the character and result channels of the bracket nesting checker,
// predicts the result of every line and compares it with what the block gives.
// ----------------------------------------------------------------------------
module line_result_checker #(
   parameter int unsigned SLOTS = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_symbol,
   input  logic                   req_symbol_present,
   input  logic                   req_line_end,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [1:0]             rsp_line_status,
   input  logic [15:0]            rsp_error_cost,
   input  logic [62:0]            rsp_completion_score,
   input  logic [31:0]            rsp_total_error_cost,
   input  logic                   csr_wr_en,
   input  bnc_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata,
   output int unsigned            mismatch_count,
   output int unsigned            lines_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] SCORE_CAP = {1'b0, bnc_pkg::SCORE_MAX};
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      bnc_pkg::status_type         status;
      logic [bnc_pkg::COST_W-1:0]  cost;
      logic [bnc_pkg::SCORE_W-1:0] score;
      logic [bnc_pkg::TOTAL_W-1:0] total;
   } line_result_type;

   // Predicted configuration, indexed by bracket kind.
   logic [bnc_pkg::COST_W-1:0]   close_cost [4];
   logic [bnc_pkg::REPAIR_W-1:0] repair_val [4];

   // Predicted line state.
   bnc_pkg::kind_type           kind_stack [SLOTS];
   int unsigned                 stack_level;
   logic                        corrupt_flag;
   logic                        overflow_flag;
   logic [bnc_pkg::COST_W-1:0]  held_cost;
   logic [bnc_pkg::TOTAL_W-1:0] cost_total;

   line_result_type expected_lines [$];

   function automatic void restore_defaults();
      close_cost[bnc_pkg::KIND_ROUND]  = bnc_pkg::COST_ROUND_RST;
      close_cost[bnc_pkg::KIND_SQUARE] = bnc_pkg::COST_SQUARE_RST;
      close_cost[bnc_pkg::KIND_CURLY]  = bnc_pkg::COST_CURLY_RST;
      close_cost[bnc_pkg::KIND_ANGLE]  = bnc_pkg::COST_ANGLE_RST;
      repair_val[bnc_pkg::KIND_ROUND]  = bnc_pkg::REPAIR_ROUND_RST;
      repair_val[bnc_pkg::KIND_SQUARE] = bnc_pkg::REPAIR_SQUARE_RST;
      repair_val[bnc_pkg::KIND_CURLY]  = bnc_pkg::REPAIR_CURLY_RST;
      repair_val[bnc_pkg::KIND_ANGLE]  = bnc_pkg::REPAIR_ANGLE_RST;
      stack_level   = 0;
      corrupt_flag  = 1'b0;
      overflow_flag = 1'b0;
      held_cost     = '0;
      cost_total    = '0;
      expected_lines.delete();
   endfunction

   function automatic void take_write(input bnc_pkg::csr_index_type idx,
                                      input logic [15:0] value);
      case (idx)
         bnc_pkg::CSR_COST_ROUND:    close_cost[bnc_pkg::KIND_ROUND]  = value;
         bnc_pkg::CSR_COST_SQUARE:   close_cost[bnc_pkg::KIND_SQUARE] = value;
         bnc_pkg::CSR_COST_CURLY:    close_cost[bnc_pkg::KIND_CURLY]  = value;
         bnc_pkg::CSR_COST_ANGLE:    close_cost[bnc_pkg::KIND_ANGLE]  = value;
         bnc_pkg::CSR_REPAIR_ROUND:
            repair_val[bnc_pkg::KIND_ROUND]  = value[bnc_pkg::REPAIR_W-1:0];
         bnc_pkg::CSR_REPAIR_SQUARE:
            repair_val[bnc_pkg::KIND_SQUARE] = value[bnc_pkg::REPAIR_W-1:0];
         bnc_pkg::CSR_REPAIR_CURLY:
            repair_val[bnc_pkg::KIND_CURLY]  = value[bnc_pkg::REPAIR_W-1:0];
         bnc_pkg::CSR_REPAIR_ANGLE:
            repair_val[bnc_pkg::KIND_ANGLE]  = value[bnc_pkg::REPAIR_W-1:0];
         default: ;
      endcase
   endfunction

   // Sort a character into opener, closer or neither, with its bracket kind.
   function automatic void classify(input logic [7:0] ch, output logic is_open,
                                    output logic is_close,
                                    output bnc_pkg::kind_type kind);
      is_open  = 1'b0;
      is_close = 1'b0;
      kind     = bnc_pkg::KIND_ROUND;
      case (ch)
         bnc_pkg::ASCII_OPEN_ROUND:   begin is_open = 1'b1;  kind = bnc_pkg::KIND_ROUND;  end
         bnc_pkg::ASCII_OPEN_SQUARE:  begin is_open = 1'b1;  kind = bnc_pkg::KIND_SQUARE; end
         bnc_pkg::ASCII_OPEN_CURLY:   begin is_open = 1'b1;  kind = bnc_pkg::KIND_CURLY;  end
         bnc_pkg::ASCII_OPEN_ANGLE:   begin is_open = 1'b1;  kind = bnc_pkg::KIND_ANGLE;  end
         bnc_pkg::ASCII_CLOSE_ROUND:  begin is_close = 1'b1; kind = bnc_pkg::KIND_ROUND;  end
         bnc_pkg::ASCII_CLOSE_SQUARE: begin is_close = 1'b1; kind = bnc_pkg::KIND_SQUARE; end
         bnc_pkg::ASCII_CLOSE_CURLY:  begin is_close = 1'b1; kind = bnc_pkg::KIND_CURLY;  end
         bnc_pkg::ASCII_CLOSE_ANGLE:  begin is_close = 1'b1; kind = bnc_pkg::KIND_ANGLE;  end
         default: ;
      endcase
   endfunction

   // Apply one character to the predicted stack. Once a line is corrupted or
   // has overflowed, the rest of it is ignored.
   function automatic void absorb_symbol(input logic [7:0] ch, input logic present);
      logic              is_open;
      logic              is_close;
      bnc_pkg::kind_type kind;
      if (!present || corrupt_flag || overflow_flag) return;
      classify(ch, is_open, is_close, kind);
      if (is_open) begin
         if (stack_level >= SLOTS) begin
            overflow_flag = 1'b1;
         end else begin
            kind_stack[stack_level] = kind;
            stack_level++;
         end
      end else if (is_close) begin
         if (stack_level > 0 && kind_stack[stack_level-1] == kind) begin
            stack_level--;
         end else begin
            corrupt_flag = 1'b1;
            held_cost    = close_cost[kind];
         end
      end
   endfunction

   // Form the result of the line that ends now and clear the line state.
   function automatic line_result_type finish_line();
      line_result_type          res;
      logic [63:0]              score;
      logic [63:0]              rep;
      logic [bnc_pkg::TOTAL_W:0] sum;
      res.status = bnc_pkg::STATUS_GOOD;
      res.cost   = '0;
      res.score  = '0;
      score      = '0;
      if (corrupt_flag) begin
         res.status = bnc_pkg::STATUS_CORRUPTED;
         res.cost   = held_cost;
         sum        = {1'b0, cost_total} + (bnc_pkg::TOTAL_W + 1)'(held_cost);
         cost_total = sum[bnc_pkg::TOTAL_W] ? bnc_pkg::TOTAL_MAX
                                            : sum[bnc_pkg::TOTAL_W-1:0];
      end else if (overflow_flag) begin
         res.status = bnc_pkg::STATUS_OVERFLOW;
      end else if (stack_level > 0) begin
         res.status = bnc_pkg::STATUS_INCOMPLETE;
         // Unwind from the top of the stack; the score saturates.
         for (int d = int'(stack_level) - 1; d >= 0; d--) begin
            rep = 64'(repair_val[kind_stack[d]]);
            if (score > (SCORE_CAP - rep) / 5) score = SCORE_CAP;
            else score = score * 5 + rep;
         end
         res.score = score[bnc_pkg::SCORE_W-1:0];
      end
      res.total     = cost_total;
      stack_level   = 0;
      corrupt_flag  = 1'b0;
      overflow_flag = 1'b0;
      held_cost     = '0;
      return res;
   endfunction

   function automatic void check_result();
      line_result_type want;
      if (expected_lines.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t checker: result with no line pending", $time);
            $display("   actual   status %0d cost %0d score %0d total %0d",
                     rsp_line_status, rsp_error_cost, rsp_completion_score,
                     rsp_total_error_cost);
         end
         return;
      end
      want = expected_lines.pop_front();
      if (rsp_line_status !== want.status || rsp_error_cost !== want.cost ||
          rsp_completion_score !== want.score || rsp_total_error_cost !== want.total) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t checker: line result mismatch", $time);
            $display("   expected status %0d cost %0d score %0d total %0d",
                     want.status, want.cost, want.score, want.total);
            $display("   actual   status %0d cost %0d score %0d total %0d",
                     rsp_line_status, rsp_error_cost, rsp_completion_score,
                     rsp_total_error_cost);
         end
      end
   endfunction

   // Everything is sampled at the rising edge, before the drivers update.
   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
      end else begin
         if (csr_wr_en) take_write(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            absorb_symbol(req_symbol, req_symbol_present);
            if (req_line_end) expected_lines.insert(expected_lines.size(), finish_line());
         end
         if (rsp_valid && rsp_ready) check_result();
      end
      lines_pending = expected_lines.size();
   end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives lines of characters into the bracket nesting checker under several
// register settings and random idling on both channels; a separate checker
// predicts each line result and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOTS         = 128;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = SLOTS + 8;
   localparam int unsigned LONG_STALL    = 300;
   localparam int unsigned PHASE_ITEMS   = 230;

   typedef struct packed {
      logic [7:0] sym;
      logic       present;
      logic       last;
   } symbol_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_symbol = '0;
   logic                   req_symbol_present = 1'b0;
   logic                   req_line_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_line_status;
   logic [15:0]            rsp_error_cost;
   logic [62:0]            rsp_completion_score;
   logic [31:0]            rsp_total_error_cost;
   logic                   csr_wr_en = 1'b0;
   bnc_pkg::csr_index_type csr_index = bnc_pkg::CSR_COST_ROUND;
   logic [15:0]            csr_wdata = '0;

   int unsigned   mismatch_count;
   int unsigned   lines_pending;
   int unsigned   cycle_count = 0;
   int unsigned   items_sent = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   rcv_idle_pct = 0;
   int unsigned   stalls_asked = 0;
   int unsigned   stalls_granted = 0;
   int unsigned   stall_left = 0;

   symbol_item_type line_items [$];
   logic [15:0]     cost_set [4];
   logic [3:0]      repair_set [4];

   bracket_nesting_checker #(.STACK_DEPTH(SLOTS)) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_symbol           (req_symbol),
      .req_symbol_present   (req_symbol_present),
      .req_line_end         (req_line_end),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_line_status      (rsp_line_status),
      .rsp_error_cost       (rsp_error_cost),
      .rsp_completion_score (rsp_completion_score),
      .rsp_total_error_cost (rsp_total_error_cost),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   line_result_checker #(.SLOTS(SLOTS)) u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_symbol           (req_symbol),
      .req_symbol_present   (req_symbol_present),
      .req_line_end         (req_line_end),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_line_status      (rsp_line_status),
      .rsp_error_cost       (rsp_error_cost),
      .rsp_completion_score (rsp_completion_score),
      .rsp_total_error_cost (rsp_total_error_cost),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .lines_pending        (lines_pending)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result receiver: random idling, plus a long hold-off whenever the
   // stimulus asks for one, so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_granted != stalls_asked) begin
         rsp_ready      <= 1'b0;
         stall_left     <= LONG_STALL;
         stalls_granted <= stalls_granted + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   function automatic logic [7:0] opener_char(input bnc_pkg::kind_type kind);
      case (kind)
         bnc_pkg::KIND_ROUND:  return bnc_pkg::ASCII_OPEN_ROUND;
         bnc_pkg::KIND_SQUARE: return bnc_pkg::ASCII_OPEN_SQUARE;
         bnc_pkg::KIND_CURLY:  return bnc_pkg::ASCII_OPEN_CURLY;
         default:              return bnc_pkg::ASCII_OPEN_ANGLE;
      endcase
   endfunction

   function automatic logic [7:0] closer_char(input bnc_pkg::kind_type kind);
      case (kind)
         bnc_pkg::KIND_ROUND:  return bnc_pkg::ASCII_CLOSE_ROUND;
         bnc_pkg::KIND_SQUARE: return bnc_pkg::ASCII_CLOSE_SQUARE;
         bnc_pkg::KIND_CURLY:  return bnc_pkg::ASCII_CLOSE_CURLY;
         default:              return bnc_pkg::ASCII_CLOSE_ANGLE;
      endcase
   endfunction

   function automatic logic [7:0] any_bracket();
      if ($urandom_range(1) != 0)
         return opener_char(bnc_pkg::kind_type'($urandom_range(3)));
      return closer_char(bnc_pkg::kind_type'($urandom_range(3)));
   endfunction

   // Append one item to the line being built.
   function automatic void append_item(input logic [7:0] sym, input logic present,
                                       input logic last);
      symbol_item_type item;
      item.sym     = sym;
      item.present = present;
      item.last    = last;
      line_items.insert(line_items.size(), item);
   endfunction

   function automatic void add_char(input logic [7:0] sym, input logic present);
      append_item(sym, present, 1'b0);
   endfunction

   // Offer one item and hold it until it is taken. The handshake is looked at
   // on the falling edge, where every input is stable.
   task automatic send_item(input logic [7:0] sym, input logic present, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_symbol         <= sym;
      req_symbol_present <= present;
      req_line_end       <= last;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_item(text[i], 1'b1, i == text.len() - 1);
   endtask

   task automatic send_line();
      foreach (line_items[i])
         send_item(line_items[i].sym, line_items[i].present, line_items[i].last);
   endtask

   // Drop valid, wait until every line result is in, then let the block settle.
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (lines_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input bnc_pkg::csr_index_type idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings();
      write_reg(bnc_pkg::CSR_COST_ROUND,    cost_set[0]);
      write_reg(bnc_pkg::CSR_COST_SQUARE,   cost_set[1]);
      write_reg(bnc_pkg::CSR_COST_CURLY,    cost_set[2]);
      write_reg(bnc_pkg::CSR_COST_ANGLE,    cost_set[3]);
      write_reg(bnc_pkg::CSR_REPAIR_ROUND,  16'(repair_set[0]));
      write_reg(bnc_pkg::CSR_REPAIR_SQUARE, 16'(repair_set[1]));
      write_reg(bnc_pkg::CSR_REPAIR_CURLY,  16'(repair_set[2]));
      write_reg(bnc_pkg::CSR_REPAIR_ANGLE,  16'(repair_set[3]));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // A line of openers. Past the stack size it overflows, and the random
   // brackets that follow must then be ignored.
   task automatic build_deep_line(input int unsigned depth);
      line_items.delete();
      repeat (depth) add_char(opener_char(bnc_pkg::kind_type'($urandom_range(3))), 1'b1);
      if (depth > SLOTS)
         repeat ($urandom_range(1, 6)) add_char(any_bracket(), 1'b1);
      append_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // A mostly well-formed line with random content, then closed, left open,
   // broken by a wrong closer, or followed by raw bracket noise.
   task automatic build_random_line();
      bnc_pkg::kind_type open_kinds [$];
      bnc_pkg::kind_type kind;
      int unsigned       roll;
      int unsigned       style;
      line_items.delete();
      style = $urandom_range(99);
      repeat ($urandom_range(0, 14)) begin
         roll = $urandom_range(99);
         if (roll < 45) begin
            kind = bnc_pkg::kind_type'($urandom_range(3));
            open_kinds.insert(open_kinds.size(), kind);
            add_char(opener_char(kind), 1'b1);
         end else if (roll < 85 && open_kinds.size() > 0) begin
            kind = open_kinds[$];
            open_kinds.delete(open_kinds.size() - 1);
            add_char(closer_char(kind), 1'b1);
         end else if (roll < 93) begin
            add_char(8'($urandom_range(255)), 1'b1);
         end else begin
            add_char(8'($urandom_range(255)), 1'b0);
         end
      end
      if (style < 45) begin
         while (open_kinds.size() > 0) begin
            kind = open_kinds[$];
            open_kinds.delete(open_kinds.size() - 1);
            add_char(closer_char(kind), 1'b1);
         end
      end else if (style >= 70 && style < 88) begin
         kind = bnc_pkg::kind_type'($urandom_range(3));
         if (open_kinds.size() > 0 && kind == open_kinds[$]) kind = kind + 2'd1;
         add_char(closer_char(kind), 1'b1);
         repeat ($urandom_range(0, 4)) add_char(any_bracket(), 1'b1);
      end else if (style >= 88) begin
         repeat ($urandom_range(1, 10)) add_char(any_bracket(), 1'b1);
      end
      // The line ends either on its last character or on an extra item.
      if (line_items.size() > 0 && $urandom_range(1) != 0)
         line_items[$].last = 1'b1;
      else
         append_item(8'($urandom_range(255)), ($urandom_range(3) == 0), 1'b1);
   endtask

   task automatic run_phase(input int unsigned depth);
      int unsigned start;
      stalls_asked <= stalls_asked + 1;
      build_deep_line(depth);
      send_line();
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         build_random_line();
         send_line();
      end
      settle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines under the reset costs.
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      send_text("()");
      send_text("[{<>}]");
      send_text("(])");
      send_text(")");
      send_text("[}");
      send_text("{>");
      send_item(bnc_pkg::ASCII_OPEN_ROUND, 1'b1, 1'b0);
      send_item(bnc_pkg::ASCII_OPEN_ANGLE, 1'b1, 1'b0);
      send_item(bnc_pkg::ASCII_OPEN_ROUND, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      settle();

      // Largest costs and repairs; a full stack saturates the score.
      send_idle_pct = 11;
      rcv_idle_pct <= 71;
      cost_set   = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      repair_set = '{4'hF, 4'hF, 4'hF, 4'hF};
      apply_settings();
      run_phase(SLOTS);

      // All zero; the first line overflows the stack.
      send_idle_pct = 71;
      rcv_idle_pct <= 11;
      cost_set   = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
      repair_set = '{4'h0, 4'h0, 4'h0, 4'h0};
      apply_settings();
      run_phase(SLOTS + 5);

      // Random settings with no random idling on either side.
      send_idle_pct = 0;
      rcv_idle_pct <= 0;
      foreach (cost_set[i]) cost_set[i] = 16'($urandom_range(16'hFFFF));
      foreach (repair_set[i]) repair_set[i] = 4'($urandom_range(15));
      apply_settings();
      run_phase(SLOTS - 1);

      if (mismatch_count == 0 && lines_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
